// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/esc_pkg.sv
// ----------------------------------------------------------------------------
// Expression syntax checker package
// Status codes, divisor scan phases and character constants.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned MaxLenDefault = 256;
  localparam int unsigned PosW          = 9;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StEmpty   = 3'd1,
    StBadChar = 3'd2,
    StClose   = 3'd3,
    StDouble  = 3'd4,
    StEndOp   = 3'd5,
    StUnbal   = 3'd6,
    StDivZero = 3'd7
  } status_e;

  // Divisor run after '/': opening parens, optional minus sign, integer, fraction
  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhParen = 3'd1,
    PhSign  = 3'd2,
    PhInt   = 3'd3,
    PhFrac  = 3'd4
  } phase_e;

  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChV      = 8'h76;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChY      = 8'h79;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] CaseBit  = 8'h20;

endpackage

// File: design/expression_syntax_checker_unit.sv
// ----------------------------------------------------------------------------
// Expression syntax checker unit
// Streams an equation byte by byte and reports its first syntax error.
// ----------------------------------------------------------------------------
// One byte enters per transaction and one byte is taken every cycle; the
// block never stalls on ordinary characters. Spaces, tabs and CR are dropped
// and A-Z lowercased before checking. A transaction with is_end_i set closes
// the equation: after the input register and the result register a single
// result transaction carries the first error code and its position in the
// cleaned text (0 when all is well), and the checker is back in its reset
// state for the next equation. The whole state update for one byte sits
// between the input register and the result register. An end marker waits
// in the input register only while the previous result is still held by
// out_stall_i. Position and depth counters saturate at MaxLen; positions
// are reported in nine bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module expression_syntax_checker_unit #(
  parameter int unsigned MaxLen = esc_pkg::MaxLenDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               ch_i,
  input  logic                     is_end_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [esc_pkg::PosW-1:0] error_position_o
);

  localparam int unsigned CntW = $clog2(MaxLen + 1);
  localparam int unsigned PadW = (CntW > esc_pkg::PosW) ? CntW : esc_pkg::PosW;

  // Saturating increment shared by the position and depth counters
  function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
    return (v < CntW'(MaxLen)) ? CntW'(v + 1'b1) : CntW'(MaxLen);
  endfunction

  function automatic logic [esc_pkg::PosW-1:0] pos_out(input logic [CntW-1:0] v);
    logic [PadW-1:0] wide;
    wide = PadW'(v);
    return wide[esc_pkg::PosW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_vld_q, in_vld_d;
  logic [7:0] ch_q, ch_d;
  logic       end_q, end_d;
  logic       adv;

  // Result register
  logic                     out_vld_q, out_vld_d;
  esc_pkg::status_e         status_q, status_d;
  logic [esc_pkg::PosW-1:0] opos_q, opos_d;

  // Checker state
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  depth_q, depth_d;
  logic             last_op_q, last_op_d;
  logic             last_bin_q, last_bin_d;
  esc_pkg::status_e err_q, err_d;
  logic [CntW-1:0]  epos_q, epos_d;
  esc_pkg::phase_e  phase_q, phase_d;
  logic             saw_dig_q, saw_dig_d;
  logic             saw_nz_q, saw_nz_d;
  logic [CntW-1:0]  slash_q, slash_d;
  logic             pend_q, pend_d;

  // An end marker may only move on once the result register is free
  assign adv        = in_vld_q && !(end_q && out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_comb begin
    in_vld_d = in_vld_q;
    ch_d     = ch_q;
    end_d    = end_q;
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
      ch_d     = ch_i;
      end_d    = is_end_i;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Character classification
  // --------------------------------------------------------------------------
  logic [7:0]      c;
  logic            is_skip, is_dig, is_binop, is_allowed;
  esc_pkg::phase_e scan_nxt;

  assign c = (ch_q inside {[esc_pkg::ChUpA:esc_pkg::ChUpZ]}) ? (ch_q | esc_pkg::CaseBit)
                                                              : ch_q;
  assign is_skip  = (ch_q == esc_pkg::ChSpace) || (ch_q == esc_pkg::ChTab)
                 || (ch_q == esc_pkg::ChCr);
  assign is_dig   = c inside {[esc_pkg::Ch0:esc_pkg::Ch9]};
  assign is_binop = c inside {esc_pkg::ChPlus, esc_pkg::ChMinus, esc_pkg::ChStar,
                              esc_pkg::ChSlash, esc_pkg::ChCaret, esc_pkg::ChV};
  assign is_allowed = is_dig || is_binop
                   || (c inside {esc_pkg::ChDot, esc_pkg::ChComma, esc_pkg::ChX,
                                 esc_pkg::ChY, esc_pkg::ChOpen, esc_pkg::ChClose});

  // Where the divisor run goes with this character; idle means it has ended
  always_comb begin
    scan_nxt = esc_pkg::PhIdle;
    case (phase_q)
      esc_pkg::PhParen: begin
        if (c == esc_pkg::ChOpen)       scan_nxt = esc_pkg::PhParen;
        else if (c == esc_pkg::ChMinus) scan_nxt = esc_pkg::PhSign;
        else if (is_dig)                scan_nxt = esc_pkg::PhInt;
        else if (c == esc_pkg::ChDot)   scan_nxt = esc_pkg::PhFrac;
      end
      esc_pkg::PhSign, esc_pkg::PhInt: begin
        if (is_dig)                     scan_nxt = esc_pkg::PhInt;
        else if (c == esc_pkg::ChDot)   scan_nxt = esc_pkg::PhFrac;
      end
      esc_pkg::PhFrac: begin
        if (is_dig)                     scan_nxt = esc_pkg::PhFrac;
      end
      default: scan_nxt = esc_pkg::PhIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // State update, one cleaned character per cycle
  // --------------------------------------------------------------------------
  logic             stop;
  esc_pkg::status_e fin_err;
  logic [CntW-1:0]  fin_pos;

  always_comb begin
    cnt_d      = cnt_q;
    depth_d    = depth_q;
    last_op_d  = last_op_q;
    last_bin_d = last_bin_q;
    err_d      = err_q;
    epos_d     = epos_q;
    phase_d    = phase_q;
    saw_dig_d  = saw_dig_q;
    saw_nz_d   = saw_nz_q;
    slash_d    = slash_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && out_stall_i;
    status_d   = status_q;
    opos_d     = opos_q;
    stop       = 1'b0;
    fin_err    = err_q;
    fin_pos    = epos_q;

    if (adv && end_q) begin
      // Close a divisor run still open at the end marker
      if (phase_q != esc_pkg::PhIdle && err_q == esc_pkg::StOk) begin
        if (saw_dig_q && !saw_nz_q) begin
          fin_err = esc_pkg::StDivZero;
          fin_pos = inc_sat(slash_q);
        end else if (pend_q) begin
          fin_err = esc_pkg::StDouble;
          fin_pos = slash_q;
        end
      end
      out_vld_d = 1'b1;
      if (fin_err != esc_pkg::StOk) begin
        status_d = fin_err;
        opos_d   = pos_out(fin_pos);
      end else if (cnt_q == '0) begin
        status_d = esc_pkg::StEmpty;
        opos_d   = '0;
      end else if (last_bin_q) begin
        status_d = esc_pkg::StEndOp;
        opos_d   = pos_out(CntW'(cnt_q - 1'b1));
      end else if (depth_q != '0) begin
        status_d = esc_pkg::StUnbal;
        opos_d   = pos_out(cnt_q);
      end else begin
        status_d = esc_pkg::StOk;
        opos_d   = '0;
      end
      // Back to reset state for the next equation
      cnt_d      = '0;
      depth_d    = '0;
      last_op_d  = 1'b1;
      last_bin_d = 1'b0;
      err_d      = esc_pkg::StOk;
      epos_d     = '0;
      phase_d    = esc_pkg::PhIdle;
      saw_dig_d  = 1'b0;
      saw_nz_d   = 1'b0;
      slash_d    = '0;
      pend_d     = 1'b0;
    end else if (adv && !is_skip) begin
      cnt_d = inc_sat(cnt_q);
      if (err_q == esc_pkg::StOk) begin
        if (phase_q != esc_pkg::PhIdle) begin
          if (scan_nxt != esc_pkg::PhIdle) begin
            phase_d = scan_nxt;
            if (is_dig) begin
              saw_dig_d = 1'b1;
              if (c != esc_pkg::Ch0) saw_nz_d = 1'b1;
            end
          end else begin
            // Run over: judge it before this character is checked
            phase_d   = esc_pkg::PhIdle;
            saw_dig_d = 1'b0;
            saw_nz_d  = 1'b0;
            pend_d    = 1'b0;
            if (saw_dig_q && !saw_nz_q) begin
              err_d  = esc_pkg::StDivZero;
              epos_d = inc_sat(slash_q);
              stop   = 1'b1;
            end else if (pend_q) begin
              err_d  = esc_pkg::StDouble;
              epos_d = slash_q;
              stop   = 1'b1;
            end
          end
        end

        if (!stop) begin
          if (!is_allowed) begin
            err_d  = esc_pkg::StBadChar;
            epos_d = cnt_q;
          end else if (c == esc_pkg::ChClose && depth_q == '0) begin
            err_d  = esc_pkg::StClose;
            epos_d = cnt_q;
          end else if (is_binop && c != esc_pkg::ChSlash && c != esc_pkg::ChMinus
                       && last_op_q) begin
            err_d  = esc_pkg::StDouble;
            epos_d = cnt_q;
          end else begin
            if (c == esc_pkg::ChOpen)  depth_d = inc_sat(depth_q);
            if (c == esc_pkg::ChClose) depth_d = CntW'(depth_q - 1'b1);
            if (is_binop) begin
              if (c == esc_pkg::ChSlash) begin
                // Start a fresh divisor run; a double operator here waits for it
                phase_d   = esc_pkg::PhParen;
                saw_dig_d = 1'b0;
                saw_nz_d  = 1'b0;
                slash_d   = cnt_q;
                pend_d    = last_op_q;
              end
              last_op_d = 1'b1;
            end else if (c != esc_pkg::ChOpen && c != esc_pkg::ChComma) begin
              last_op_d = 1'b0;
            end
            last_bin_d = is_binop;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
      depth_q    <= '0;
      last_op_q  <= 1'b1;
      last_bin_q <= 1'b0;
      err_q      <= esc_pkg::StOk;
      epos_q     <= '0;
      phase_q    <= esc_pkg::PhIdle;
      saw_dig_q  <= 1'b0;
      saw_nz_q   <= 1'b0;
      slash_q    <= '0;
      pend_q     <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      out_vld_q  <= out_vld_d;
      cnt_q      <= cnt_d;
      depth_q    <= depth_d;
      last_op_q  <= last_op_d;
      last_bin_q <= last_bin_d;
      err_q      <= err_d;
      epos_q     <= epos_d;
      phase_q    <= phase_d;
      saw_dig_q  <= saw_dig_d;
      saw_nz_q   <= saw_nz_d;
      slash_q    <= slash_d;
      pend_q     <= pend_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    end_q    <= end_d;
    status_q <= status_d;
    opos_q   <= opos_d;
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = status_q;
  assign error_position_o = opos_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ESC_ASSERT_IMP(a_err_no_scan, clk_i, rst_ni, err_q != esc_pkg::StOk,
                  phase_q == esc_pkg::PhIdle, "divisor scan open after an error")
  `ESC_ASSERT_IMP(a_pend_in_scan, clk_i, rst_ni, pend_q,
                  phase_q != esc_pkg::PhIdle, "held double op with no divisor scan")
  `ESC_ASSERT_IMP(a_nz_has_dig, clk_i, rst_ni, saw_nz_q, saw_dig_q,
                  "nonzero digit flagged without any digit")
  `ESC_ASSERT_IMP(a_depth_le_cnt, clk_i, rst_ni, 1'b1, depth_q <= cnt_q,
                  "paren depth exceeds character count")
  `ESC_ASSERT_IMP(a_ok_pos_zero, clk_i, rst_ni,
                  out_vld_q && status_q == esc_pkg::StOk, opos_q == '0,
                  "ok result with nonzero position")
  `ESC_ASSERT_NXT(a_end_clears, clk_i, rst_ni, adv && end_q,
                  cnt_q == '0 && err_q == esc_pkg::StOk && out_vld_q,
                  "end marker did not produce a result and clear state")

endmodule
